// ===== hdl/osrc_pkg.sv =====
package osrc_pkg;

    // operation codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_INSERT     = 4'd0,
        MODE_REMOVE     = 4'd1,
        MODE_LOWERBOUND = 4'd2,
        MODE_MIN        = 4'd3,
        MODE_MAX        = 4'd4,
        MODE_POPMIN     = 4'd5,
        MODE_POPMAX     = 4'd6,
        MODE_COUNT      = 4'd7,
        MODE_NEXT       = 4'd8,
        MODE_PREV       = 4'd9,
        MODE_GET        = 4'd10,
        MODE_ERASE      = 4'd11,
        MODE_AT         = 4'd12,
        MODE_POPAT      = 4'd13,
        MODE_RANK       = 4'd14
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_VALUE   = 3'd1,
        STS_MISSING    = 3'd2,
        STS_EMPTY      = 3'd3,
        STS_RANGE      = 3'd4,
        STS_CURSOR_END = 3'd5,
        STS_FULL       = 3'd6
    } t_status;

    // change applied to the key cells
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOCATE,
        S_DECIDE,
        S_APPLY
    } t_state;

    // input item
    typedef struct packed {
        logic [3:0]         mode;
        logic signed [63:0] key;
        logic signed [15:0] position;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] value;
        logic               inserted;
        logic [14:0]        number;
    } t_rsp;

    // controller to datapath step commands
    typedef struct packed {
        logic capture;
        logic locate;
        logic decide;
        logic apply;
    } t_ctl;

endpackage

// ===== hdl/osrc_ctrl.sv =====
module osrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output osrc_pkg::t_ctl  o_ctl
);

    osrc_pkg::t_state r_state;
    osrc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osrc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = osrc_pkg::S_LOCATE;
                end
            end
            osrc_pkg::S_LOCATE: n_state = osrc_pkg::S_DECIDE;
            osrc_pkg::S_DECIDE: n_state = osrc_pkg::S_APPLY;
            osrc_pkg::S_APPLY:  n_state = osrc_pkg::S_IDLE;
            default:            n_state = osrc_pkg::S_IDLE;
        endcase
    end

    // step commands
    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        case (r_state)
            osrc_pkg::S_IDLE: begin
                o_busy      = 1'b0;
                o_ctl.capture = i_start;
            end
            osrc_pkg::S_LOCATE: o_ctl.locate = 1'b1;
            osrc_pkg::S_DECIDE: o_ctl.decide = 1'b1;
            osrc_pkg::S_APPLY:  o_ctl.apply  = 1'b1;
            default:            o_busy = 1'b0;
        endcase
    end

endmodule

// ===== hdl/osrc_dp.sv =====
module osrc_dp #(
    parameter int CAPACITY = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  osrc_pkg::t_ctl  i_ctl,
    input  osrc_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    output osrc_pkg::t_rsp  o_rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // key cells, one per rank
    logic signed [63:0] r_cell [CAPACITY];
    logic signed [63:0] w_next [CAPACITY];
    logic signed [63:0] w_prev [CAPACITY];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_cursor;

    // captured item
    logic [3:0]         r_mode;
    logic signed [63:0] r_key;
    logic signed [15:0] r_pos;

    // per cell compare results
    logic [CAPACITY-1:0] r_lt;
    logic [CAPACITY-1:0] r_eq;

    // decision
    osrc_pkg::t_op      r_op,    n_op;
    logic [IW-1:0]      r_idx,   n_idx;
    logic               r_use_b, n_use_b;
    logic               r_zero,  n_zero;
    osrc_pkg::t_status  r_st,    n_st;
    logic               r_ins,   n_ins;
    logic [14:0]        r_num,   n_num;
    logic [CW-1:0]      r_new_cur, n_new_cur;

    logic               r_valid;
    osrc_pkg::t_rsp     r_rsp;

    logic [CW-1:0]      w_lb;
    logic               w_found;
    logic [CW:0]        w_lb_p1;
    logic [CW:0]        w_cur_p1;
    logic [CW-1:0]      w_cur_m1;
    logic [CW-1:0]      w_cnt_m1;
    logic signed [17:0] w_pos_ext;
    logic signed [17:0] w_cnt_s;
    logic signed [17:0] w_pe;
    logic signed [63:0] w_rd_a;
    logic signed [63:0] w_rd_b;

    // fixed neighbor taps for shifting
    for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
        if (g == CAPACITY - 1) begin : g_top
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = r_cell[g+1];
        end
        if (g == 0) begin : g_bot
            assign w_prev[g] = '0;
        end else begin : g_up
            assign w_prev[g] = r_cell[g-1];
        end
    end

    // capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_mode <= i_cmd.mode;
            r_key  <= i_cmd.key;
            r_pos  <= i_cmd.position;
        end
    end

    // all cells compare against the key at once
    always_ff @(posedge i_clk) begin
        if (i_ctl.locate) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_lt[i] <= (i < int'(r_count)) && (r_cell[i] < r_key);
                r_eq[i] <= (i < int'(r_count)) && (r_cell[i] == r_key);
            end
        end
    end

    // lower bound rank: first cell not below the key
    always_comb begin
        w_lb = CW'(CAPACITY);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_lt[i]) begin
                w_lb = CW'(i);
            end
        end
    end

    assign w_found   = |r_eq;
    assign w_lb_p1   = {1'b0, w_lb} + (CW+1)'(1);
    assign w_cur_p1  = {1'b0, r_cursor} + (CW+1)'(1);
    assign w_cur_m1  = r_cursor - CW'(1);
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_pos_ext = 18'(r_pos);
    assign w_cnt_s   = $signed({{(18-CW){1'b0}}, r_count});
    assign w_pe      = r_pos[15] ? (w_pos_ext + w_cnt_s) : w_pos_ext;

    // per mode decision
    always_comb begin
        n_op      = osrc_pkg::OP_NONE;
        n_idx     = '0;
        n_use_b   = 1'b0;
        n_zero    = 1'b1;
        n_st      = osrc_pkg::STS_OK;
        n_ins     = 1'b0;
        n_num     = '0;
        n_new_cur = r_cursor;
        case (osrc_pkg::t_mode'(r_mode))
            osrc_pkg::MODE_INSERT: begin
                if (w_found) begin
                    n_new_cur = w_lb;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_st = osrc_pkg::STS_FULL;
                end else begin
                    n_op      = osrc_pkg::OP_INS;
                    n_idx     = w_lb[IW-1:0];
                    n_new_cur = w_lb;
                    n_ins     = 1'b1;
                end
            end
            osrc_pkg::MODE_REMOVE: begin
                if (w_found) begin
                    n_op      = osrc_pkg::OP_DEL;
                    n_idx     = w_lb[IW-1:0];
                    n_new_cur = w_lb;
                    if (w_lb_p1 >= {1'b0, r_count}) begin
                        n_st = osrc_pkg::STS_NO_VALUE;
                    end else begin
                        n_use_b = 1'b1;
                        n_zero  = 1'b0;
                    end
                end else begin
                    n_new_cur = r_count;
                    n_st      = osrc_pkg::STS_MISSING;
                end
            end
            osrc_pkg::MODE_LOWERBOUND: begin
                n_new_cur = w_lb;
                if (w_lb >= r_count) begin
                    n_st = osrc_pkg::STS_NO_VALUE;
                end else begin
                    n_idx  = w_lb[IW-1:0];
                    n_zero = 1'b0;
                end
            end
            osrc_pkg::MODE_MIN, osrc_pkg::MODE_MAX,
            osrc_pkg::MODE_POPMIN, osrc_pkg::MODE_POPMAX: begin
                if (r_count == '0) begin
                    n_st = osrc_pkg::STS_EMPTY;
                end else begin
                    n_zero = 1'b0;
                    if (r_mode == osrc_pkg::MODE_MIN || r_mode == osrc_pkg::MODE_POPMIN) begin
                        n_idx     = '0;
                        n_new_cur = '0;
                    end else begin
                        n_idx     = w_cnt_m1[IW-1:0];
                        n_new_cur = w_cnt_m1;
                    end
                    if (r_mode == osrc_pkg::MODE_POPMIN || r_mode == osrc_pkg::MODE_POPMAX) begin
                        n_op = osrc_pkg::OP_DEL;
                    end
                end
            end
            osrc_pkg::MODE_COUNT: begin
                n_num = 15'(r_count);
            end
            osrc_pkg::MODE_NEXT: begin
                if (r_cursor >= r_count) begin
                    n_st = osrc_pkg::STS_NO_VALUE;
                end else begin
                    n_new_cur = w_cur_p1[CW-1:0];
                    if (w_cur_p1 >= {1'b0, r_count}) begin
                        n_st = osrc_pkg::STS_NO_VALUE;
                    end else begin
                        n_idx   = r_cursor[IW-1:0];
                        n_use_b = 1'b1;
                        n_zero  = 1'b0;
                    end
                end
            end
            osrc_pkg::MODE_PREV: begin
                if (r_cursor == '0) begin
                    n_st = osrc_pkg::STS_NO_VALUE;
                end else begin
                    n_new_cur = w_cur_m1;
                    if (w_cur_m1 >= r_count) begin
                        n_st = osrc_pkg::STS_NO_VALUE;
                    end else begin
                        n_idx  = w_cur_m1[IW-1:0];
                        n_zero = 1'b0;
                    end
                end
            end
            osrc_pkg::MODE_GET: begin
                if (r_cursor >= r_count) begin
                    n_st = osrc_pkg::STS_NO_VALUE;
                end else begin
                    n_idx  = r_cursor[IW-1:0];
                    n_zero = 1'b0;
                end
            end
            osrc_pkg::MODE_ERASE: begin
                if (r_cursor >= r_count) begin
                    n_st = osrc_pkg::STS_CURSOR_END;
                end else begin
                    n_op  = osrc_pkg::OP_DEL;
                    n_idx = r_cursor[IW-1:0];
                    if (w_cur_p1 >= {1'b0, r_count}) begin
                        n_st = osrc_pkg::STS_NO_VALUE;
                    end else begin
                        n_use_b = 1'b1;
                        n_zero  = 1'b0;
                    end
                end
            end
            osrc_pkg::MODE_AT, osrc_pkg::MODE_POPAT: begin
                if (w_pe < 18'sd0 || w_pe >= w_cnt_s) begin
                    n_st = osrc_pkg::STS_RANGE;
                end else begin
                    n_idx     = w_pe[IW-1:0];
                    n_new_cur = w_pe[CW-1:0];
                    n_zero    = 1'b0;
                    if (r_mode == osrc_pkg::MODE_POPAT) begin
                        n_op = osrc_pkg::OP_DEL;
                    end
                end
            end
            osrc_pkg::MODE_RANK: begin
                n_num = 15'(w_lb);
            end
            default: begin
                n_st = osrc_pkg::STS_NO_VALUE;
            end
        endcase
    end

    // decision register
    always_ff @(posedge i_clk) begin
        if (i_ctl.decide) begin
            r_op      <= n_op;
            r_idx     <= n_idx;
            r_use_b   <= n_use_b;
            r_zero    <= n_zero;
            r_st      <= n_st;
            r_ins     <= n_ins;
            r_num     <= n_num;
            r_new_cur <= n_new_cur;
        end
    end

    assign w_rd_a = r_cell[r_idx];
    assign w_rd_b = w_next[r_idx];

    // cells shift open or closed in parallel
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_op == osrc_pkg::OP_INS) begin
                    if (i == int'(r_idx)) begin
                        r_cell[i] <= r_key;
                    end else if (i > int'(r_idx)) begin
                        r_cell[i] <= w_prev[i];
                    end
                end else if (r_op == osrc_pkg::OP_DEL) begin
                    if (i >= int'(r_idx)) begin
                        r_cell[i] <= w_next[i];
                    end
                end
            end
        end
    end

    // count, cursor and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_ctl.apply;
            if (i_ctl.apply) begin
                r_cursor <= r_new_cur;
                if (r_op == osrc_pkg::OP_INS) begin
                    r_count <= r_count + CW'(1);
                end else if (r_op == osrc_pkg::OP_DEL) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            r_rsp.status   <= r_st;
            r_rsp.value    <= r_zero ? 64'sd0 : (r_use_b ? w_rd_b : w_rd_a);
            r_rsp.inserted <= r_ins;
            r_rsp.number   <= r_num;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hdl/ordered_set_with_rank_and_cursor_top.sv =====
// Ordered set of distinct signed 64-bit keys with rank access and a cursor.
// An item is taken when start is high and busy is low; every item gives one
// result, shown for a single cycle with o_valid high, and the receiver cannot
// stall it. From transfer to result each item passes through capture, a
// parallel compare over all key cells, a decision step, then the parallel
// shift of the cells. A new item can be taken in the cycle the previous
// result is shown, and not while an item is in progress, whatever the fill.
// No clearing pass is needed after reset.
module ordered_set_with_rank_and_cursor_top #(
    parameter int CAPACITY = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  osrc_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    output osrc_pkg::t_rsp  o_rsp
);

    osrc_pkg::t_ctl w_ctl;

    // sequencer
    osrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctl   (w_ctl)
    );

    // key cells and decision logic
    osrc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== hdl/osrc_check.sv =====
module osrc_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_valid,
    input  osrc_pkg::t_rsp  o_rsp
);

    // every transfer is followed by its result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result missing after transfer");

    // block is busy right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after transfer");

    // a result is shown for one cycle only
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result repeated");

    // failed operations return a zero value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != osrc_pkg::STS_OK) |-> (o_rsp.value == '0))
        else $error("value not zero on failure");

endmodule

bind ordered_set_with_rank_and_cursor_top osrc_check u_osrc_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
